FILE: hw/rtl/apu_frame_sequencer_core_macros.svh
// Assertion helpers for the frame sequencer core RTL.
`ifndef APU_FRAME_SEQUENCER_CORE_MACROS_SVH
`define APU_FRAME_SEQUENCER_CORE_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is low.
`define AFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent, disabled while reset is low.
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/afs_pkg.sv
`timescale 1ns / 1ps

package afs_pkg;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_QUARTER_PERIOD = 2'd1;
    localparam logic [1:0] CFG_HALF_PERIOD    = 2'd2;

    localparam int PERIOD_W = 15;
    localparam int COUNT_W  = 16;

    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST   = 15'd14914;
    localparam logic [PERIOD_W-1:0] QUARTER_PERIOD_RST = 15'd3728;
    localparam logic [PERIOD_W-1:0] HALF_PERIOD_RST    = 15'd7456;

    // Sound unit register addresses (low five bits).
    localparam logic [4:0] REG_STATUS  = 5'd21;
    localparam logic [4:0] REG_FRAME   = 5'd23;

    // Counter load values.
    localparam logic signed [COUNT_W-1:0] CNT_START   = 16'sd4;
    localparam logic signed [COUNT_W-1:0] CNT_RELOAD  = -16'sd1;
    localparam logic signed [COUNT_W-1:0] CNT_RELOAD2 = -16'sd2;
    localparam logic signed [COUNT_W-1:0] QUARTER_HOLD = 16'sd4;
    localparam logic signed [COUNT_W-1:0] HALF_HOLD   = 16'sd3730;

    localparam logic [1:0] WINDOW_LEN = 2'd3;

    // Bits of the written frame control byte and of the status byte.
    localparam int BIT_MODE    = 7;
    localparam int BIT_INHIBIT = 6;
    localparam int BIT_KEEP    = 5;

    typedef struct packed {
        logic [PERIOD_W-1:0] frame_period;
        logic [PERIOD_W-1:0] quarter_period;
        logic [PERIOD_W-1:0] half_period;
    } t_periods;

    typedef struct packed {
        t_opcode    opcode;
        logic [4:0] reg_index;
        logic [7:0] wdata;
        logic       dmc_irq;
    } t_item;

    typedef struct packed {
        logic       env_clock;
        logic       length_clock;
        logic       irq_flag;
        logic [7:0] rdata;
    } t_result;

    typedef struct packed {
        logic                      odd_phase;
        logic                      step_mode;
        logic                      irq_enable;
        logic                      irq_pending;
        logic signed [COUNT_W-1:0] frame_count;
        logic signed [COUNT_W-1:0] quarter_count;
        logic signed [COUNT_W-1:0] half_count;
        logic                      half_toggle;
        logic                      irq_window;
        logic [1:0]                window_count;
        logic                      env_due;
        logic                      length_due;
        logic                      access_pending;
        logic                      access_is_write;
        logic [4:0]                access_index;
        logic [7:0]                bus_latch;
    } t_seq_state;

    localparam t_seq_state SEQ_STATE_RST = '{
        odd_phase:       1'b0,
        step_mode:       1'b0,
        irq_enable:      1'b1,
        irq_pending:     1'b0,
        frame_count:     CNT_START,
        quarter_count:   CNT_START,
        half_count:      CNT_START,
        half_toggle:     1'b0,
        irq_window:      1'b0,
        window_count:    2'd0,
        env_due:         1'b0,
        length_due:      1'b0,
        access_pending:  1'b0,
        access_is_write: 1'b0,
        access_index:    5'd0,
        bus_latch:       8'd0
    };

endpackage

FILE: hw/rtl/afs_cfg_regs.sv
`timescale 1ns / 1ps

module afs_cfg_regs
    import afs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    output t_periods            o_periods
);

    t_periods r_periods;
    t_periods n_periods;

    // Decode the write; an index past the last register is dropped.
    always_comb begin
        n_periods = r_periods;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_PERIOD:   n_periods.frame_period   = i_cfg_wdata;
                CFG_QUARTER_PERIOD: n_periods.quarter_period = i_cfg_wdata;
                CFG_HALF_PERIOD:    n_periods.half_period    = i_cfg_wdata;
                default:            n_periods = r_periods;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods.frame_period   <= FRAME_PERIOD_RST;
            r_periods.quarter_period <= QUARTER_PERIOD_RST;
            r_periods.half_period    <= HALF_PERIOD_RST;
        end else begin
            r_periods <= n_periods;
        end
    end

    assign o_periods = r_periods;

endmodule

FILE: hw/rtl/afs_seq_logic.sv
`timescale 1ns / 1ps

module afs_seq_logic
    import afs_pkg::*;
(
    input  t_seq_state i_state,
    input  t_periods   i_periods,
    input  t_item      i_item,
    output t_seq_state o_state,
    output t_result    o_result
);

    t_seq_state                nx;
    t_result                   res;
    logic signed [COUNT_W-1:0] frame_inc;
    logic signed [COUNT_W-1:0] quarter_inc;
    logic signed [COUNT_W-1:0] half_inc;
    logic signed [COUNT_W-1:0] frame_lim;
    logic signed [COUNT_W-1:0] quarter_lim;
    logic signed [COUNT_W-1:0] half_lim;
    logic [7:0]                status;

    // Counter increments and their limits, compared as signed values.
    assign frame_inc   = i_state.frame_count + 16'sd1;
    assign quarter_inc = i_state.quarter_count + 16'sd1;
    assign half_inc    = i_state.half_count + 16'sd1;
    assign frame_lim   = $signed({1'b0, i_periods.frame_period});
    assign quarter_lim = $signed({1'b0, i_periods.quarter_period});
    assign half_lim    = $signed({1'b0, i_periods.half_period});

    // Status byte: sample interrupt, frame interrupt, and one bus bit kept.
    assign status = {i_item.dmc_irq, i_state.irq_pending,
                     i_state.bus_latch[BIT_KEEP], 5'd0};

    // Next state and result for one item.
    always_comb begin
        nx  = i_state;
        res = '0;
        case (i_item.opcode)
            OP_TICK: begin
                nx.odd_phase     = !i_state.odd_phase;
                res.env_clock    = i_state.env_due;
                res.length_clock = i_state.length_due;
                nx.env_due       = 1'b0;
                nx.length_due    = 1'b0;

                // Even tick: advance the three counters.
                if (!nx.odd_phase) begin
                    if (frame_inc >= frame_lim) begin
                        nx.frame_count  = CNT_RELOAD;
                        nx.irq_window   = 1'b1;
                        nx.window_count = WINDOW_LEN;
                    end else begin
                        nx.frame_count = frame_inc;
                    end

                    if (quarter_inc >= quarter_lim) begin
                        nx.quarter_count = CNT_RELOAD;
                        if (nx.irq_window && i_state.step_mode) begin
                            nx.quarter_count = QUARTER_HOLD;
                        end else begin
                            nx.env_due = 1'b1;
                        end
                    end else begin
                        nx.quarter_count = quarter_inc;
                    end

                    if (half_inc >= half_lim) begin
                        if (nx.irq_window && i_state.step_mode) begin
                            nx.half_count  = HALF_HOLD;
                            nx.half_toggle = 1'b1;
                        end else begin
                            nx.half_toggle = !i_state.half_toggle;
                            nx.half_count  = i_state.half_toggle ? CNT_RELOAD : CNT_RELOAD2;
                            nx.length_due  = 1'b1;
                        end
                    end else begin
                        nx.half_count = half_inc;
                    end

                    // Apply the latched register access.
                    if (i_state.access_pending) begin
                        nx.access_pending = 1'b0;
                        if (i_state.access_index == REG_STATUS) begin
                            if (!i_state.access_is_write) begin
                                nx.irq_pending = 1'b0;
                            end
                        end else if (i_state.access_index == REG_FRAME
                                     && i_state.access_is_write) begin
                            nx.step_mode     = i_state.bus_latch[BIT_MODE];
                            nx.irq_enable    = !i_state.bus_latch[BIT_INHIBIT];
                            nx.quarter_count = CNT_RELOAD;
                            nx.half_count    = CNT_RELOAD;
                            nx.frame_count   = CNT_RELOAD;
                            nx.half_toggle   = 1'b0;
                            nx.length_due    = i_state.bus_latch[BIT_MODE];
                            nx.env_due       = i_state.bus_latch[BIT_MODE];
                            nx.irq_window    = 1'b0;
                            if (i_state.bus_latch[BIT_INHIBIT]) begin
                                nx.irq_pending = 1'b0;
                            end
                        end
                    end
                end

                // Interrupt window: raise the flag and count the window down.
                if (nx.irq_window) begin
                    if (!nx.step_mode && nx.irq_enable) begin
                        nx.irq_pending = 1'b1;
                    end
                    nx.window_count = nx.window_count - 2'd1;
                    if (nx.window_count == 2'd0) begin
                        nx.irq_window = 1'b0;
                    end
                end
            end
            OP_WRITE: begin
                nx.bus_latch       = i_item.wdata;
                nx.access_index    = i_item.reg_index;
                nx.access_pending  = 1'b1;
                nx.access_is_write = 1'b1;
            end
            OP_READ: begin
                nx.access_index    = i_item.reg_index;
                nx.access_pending  = 1'b1;
                nx.access_is_write = 1'b0;
                if (i_item.reg_index == REG_STATUS) begin
                    nx.bus_latch = status;
                    res.rdata    = status;
                end
            end
            default: begin
                nx = i_state;
            end
        endcase
        res.irq_flag = nx.irq_pending;
    end

    assign o_state  = nx;
    assign o_result = res;

endmodule

FILE: hw/rtl/apu_frame_sequencer_core.sv
`timescale 1ns / 1ps
// Frame sequencer of a console sound unit.
// Input stream (s_axis_*): one item per CPU cycle event. tuser carries the
// kind (tick, register write, register read); tdata carries the register
// index, the write byte and the sample channel interrupt bit.
// Output stream (m_axis_*): exactly one result per input item, in order,
// with the envelope and length clock pulses, the frame interrupt flag and
// the status byte returned by a read of register 21.
// Configuration port (i_cfg_*): the frame, quarter and half periods; the user
// writes them only while the block is idle; the block does not enforce this.
// An accepted item waits in the input register; its result is registered in
// the output register once that register is free.
// Throughput is one item per cycle unless the receiver stalls: the whole
// update of the sequencer state is a single pass of logic between the input
// register and the result register, and that logic feeds the state register.
// Reset returns the counters to four, the interrupt flag to clear and the
// interrupt inhibit to off; both streams come up empty.
// When the receiver stalls, the finished result waits in the output register
// and one more item is held in the input register; tready then drops.
module apu_frame_sequencer_core
    import afs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [4:0] reg_index, [12:5] wdata, [13] dmc_irq, [15:14] zero
    input  logic [15:0]         s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] env_clock, [1] length_clock, [2] irq_flag, [10:3] rdata,
    // [15:11] zero
    output logic [15:0]         m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [PERIOD_W-1:0] i_cfg_wdata
);

`include "apu_frame_sequencer_core_macros.svh"

    t_periods   w_periods;
    t_seq_state r_state;
    t_seq_state w_state_nx;
    t_result    w_result;
    t_item      r_in;
    t_result    r_out;
    logic       r_in_valid;
    logic       n_in_valid;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_advance;
    logic       w_in_take;

    afs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_periods   (w_periods)
    );

    afs_seq_logic u_seq_logic (
        .i_state  (r_state),
        .i_periods(w_periods),
        .i_item   (r_in),
        .o_state  (w_state_nx),
        .o_result (w_result)
    );

    // Handshake: the input register moves on when the output register is free.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= SEQ_STATE_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_state <= w_state_nx;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.opcode    <= t_opcode'(s_axis_tuser);
            r_in.reg_index <= s_axis_tdata[4:0];
            r_in.wdata     <= s_axis_tdata[12:5];
            r_in.dmc_irq   <= s_axis_tdata[13];
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.rdata, r_out.irq_flag,
                            r_out.length_clock, r_out.env_clock};

    // Register accesses never issue envelope or length clocks.
    `AFS_ASSERT_NEXT(a_access_no_clock, i_clk, i_rst_n,
        w_advance && r_in.opcode != OP_TICK,
        !r_out.env_clock && !r_out.length_clock, "clock pulse on an access item")

    // With the interrupt inhibited the frame flag stays clear.
    `AFS_ASSERT_IMPL(a_inhibit_clears, i_clk, i_rst_n,
        !r_state.irq_enable, !r_state.irq_pending, "frame flag set while inhibited")

    // The channel status bits are not driven by this block.
    `AFS_ASSERT_IMPL(a_status_low_zero, i_clk, i_rst_n,
        r_out_valid, r_out.rdata[4:0] == 5'd0, "channel status bits set")

    // A held item is never dropped while the output is stalled.
    `AFS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n,
        r_in_valid && !w_out_free, r_in_valid, "pending item lost")

endmodule

FILE: verif/apu_frame_sequencer_core_checker.sv
`timescale 1ns / 1ps

module apu_frame_sequencer_core_checker
    import afs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // [4:0] reg_index, [12:5] wdata, [13] dmc_irq, [15:14] zero
    input  logic [15:0]         i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]          i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // [0] env_clock, [1] length_clock, [2] irq_flag, [10:3] rdata, [15:11] zero
    input  logic [15:0]         i_m_tdata,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    output int                  o_failures,
    output int                  o_outstanding,
    output int                  o_checked,
    output int                  o_env_pulses,
    output int                  o_len_pulses,
    output int                  o_irq_results
);

    // Positions in the status byte.
    localparam int STATUS_DMC_BIT  = BIT_MODE;
    localparam int STATUS_IRQ_BIT  = BIT_INHIBIT;
    localparam int STATUS_KEEP_BIT = BIT_KEEP;

    // Predicted sequencer state and period registers.
    logic                      odd_phase;
    logic                      step_mode;
    logic                      irq_enable;
    logic                      irq_pending;
    logic signed [COUNT_W-1:0] frame_cnt;
    logic signed [COUNT_W-1:0] quarter_cnt;
    logic signed [COUNT_W-1:0] half_cnt;
    logic                      half_toggle;
    logic                      irq_window;
    logic [1:0]                window_cnt;
    logic                      env_due;
    logic                      length_due;
    logic                      access_pending;
    logic                      access_is_write;
    logic [4:0]                access_index;
    logic [7:0]                bus_latch;
    logic [PERIOD_W-1:0]       frame_period;
    logic [PERIOD_W-1:0]       quarter_period;
    logic [PERIOD_W-1:0]       half_period;

    // Results predicted for accepted items, oldest first.
    t_result                   pending_results[$];

    task automatic reset_sequencer();
        odd_phase       = 1'b0;
        step_mode       = 1'b0;
        irq_enable      = 1'b1;
        irq_pending     = 1'b0;
        frame_cnt       = CNT_START;
        quarter_cnt     = CNT_START;
        half_cnt        = CNT_START;
        half_toggle     = 1'b0;
        irq_window      = 1'b0;
        window_cnt      = 2'd0;
        env_due         = 1'b0;
        length_due      = 1'b0;
        access_pending  = 1'b0;
        access_is_write = 1'b0;
        access_index    = 5'd0;
        bus_latch       = 8'd0;
        frame_period    = FRAME_PERIOD_RST;
        quarter_period  = QUARTER_PERIOD_RST;
        half_period     = HALF_PERIOD_RST;
    endtask

    // A counter expires once it reaches its period; both sides are compared as signed.
    function automatic logic period_reached(input logic signed [COUNT_W-1:0] cnt,
                                            input logic [PERIOD_W-1:0] period);
        return cnt >= $signed({1'b0, period});
    endfunction

    // Counter update of an even tick, followed by the latched register access.
    function automatic void advance_even_tick();
        frame_cnt = frame_cnt + 16'sd1;
        if (period_reached(frame_cnt, frame_period)) begin
            frame_cnt  = CNT_RELOAD;
            irq_window = 1'b1;
            window_cnt = WINDOW_LEN;
        end

        quarter_cnt = quarter_cnt + 16'sd1;
        if (period_reached(quarter_cnt, quarter_period)) begin
            quarter_cnt = CNT_RELOAD;
            if (irq_window && step_mode)
                quarter_cnt = QUARTER_HOLD;
            else
                env_due = 1'b1;
        end

        half_cnt = half_cnt + 16'sd1;
        if (period_reached(half_cnt, half_period)) begin
            half_toggle = !half_toggle;
            half_cnt    = half_toggle ? CNT_RELOAD2 : CNT_RELOAD;
            if (irq_window && step_mode) begin
                half_cnt    = HALF_HOLD;
                half_toggle = 1'b1;
            end else begin
                length_due = 1'b1;
            end
        end

        if (access_pending) begin
            access_pending = 1'b0;
            if (access_index == REG_STATUS) begin
                if (!access_is_write)
                    irq_pending = 1'b0;
            end else if (access_index == REG_FRAME && access_is_write) begin
                step_mode   = bus_latch[BIT_MODE];
                irq_enable  = !bus_latch[BIT_INHIBIT];
                quarter_cnt = CNT_RELOAD;
                half_cnt    = CNT_RELOAD;
                frame_cnt   = CNT_RELOAD;
                half_toggle = 1'b0;
                length_due  = step_mode;
                env_due     = step_mode;
                irq_window  = 1'b0;
                if (!irq_enable)
                    irq_pending = 1'b0;
            end
        end
    endfunction

    // Work out the result of one CPU event and advance the predicted state.
    function automatic t_result predict_cpu_event(input logic [1:0] kind,
                                                  input logic [4:0] index,
                                                  input logic [7:0] wbyte,
                                                  input logic       dmc);
        t_result    res;
        logic [7:0] status;
        res = '0;
        case (kind)
            OP_TICK: begin
                odd_phase        = !odd_phase;
                res.env_clock    = env_due;
                res.length_clock = length_due;
                env_due          = 1'b0;
                length_due       = 1'b0;
                if (!odd_phase)
                    advance_even_tick();
                if (irq_window) begin
                    if (!step_mode && irq_enable)
                        irq_pending = 1'b1;
                    window_cnt = window_cnt - 2'd1;
                    if (window_cnt == 2'd0)
                        irq_window = 1'b0;
                end
            end
            OP_WRITE: begin
                bus_latch       = wbyte;
                access_index    = index;
                access_pending  = 1'b1;
                access_is_write = 1'b1;
            end
            OP_READ: begin
                access_index    = index;
                access_pending  = 1'b1;
                access_is_write = 1'b0;
                if (index == REG_STATUS) begin
                    status                  = 8'd0;
                    status[STATUS_KEEP_BIT] = bus_latch[STATUS_KEEP_BIT];
                    status[STATUS_IRQ_BIT]  = irq_pending;
                    status[STATUS_DMC_BIT]  = dmc;
                    bus_latch               = status;
                    res.rdata               = status;
                end
            end
            default: begin
                // The unused kind leaves the state alone.
            end
        endcase
        res.irq_flag = irq_pending;
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_failures++;
        end
    endtask

    // Follow both streams and the period writes at every rising edge.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            reset_sequencer();
            pending_results.delete();
            o_failures    = 0;
            o_checked     = 0;
            o_env_pulses  = 0;
            o_len_pulses  = 0;
            o_irq_results = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_PERIOD:   frame_period   = i_cfg_wdata;
                    CFG_QUARTER_PERIOD: quarter_period = i_cfg_wdata;
                    CFG_HALF_PERIOD:    half_period    = i_cfg_wdata;
                    default:            ;
                endcase
            end

            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(predict_cpu_event(i_s_tuser, i_s_tdata[4:0],
                                                            i_s_tdata[12:5], i_s_tdata[13]));

            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result 0x%04h arrived with no item waiting for it", i_m_tdata);
                    o_failures++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("env_clock", want.env_clock, i_m_tdata[0]);
                    compare_field("length_clock", want.length_clock, i_m_tdata[1]);
                    compare_field("irq_flag", want.irq_flag, i_m_tdata[2]);
                    compare_field("rdata", want.rdata, i_m_tdata[10:3]);
                    o_checked++;
                    o_env_pulses  += want.env_clock;
                    o_len_pulses  += want.length_clock;
                    o_irq_results += want.irq_flag;
                end
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

FILE: verif/apu_frame_sequencer_core_tb.sv
`timescale 1ns / 1ps

module apu_frame_sequencer_core_tb;
    import afs_pkg::*;

    // Item kind outside the defined set, and register indexes at the ends of the range.
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [4:0] REG_FIRST_INDEX = 5'd0;
    localparam logic [4:0] REG_LAST_INDEX  = 5'd31;

    localparam logic [7:0] CTL_FOUR_STEP = 8'h00;
    localparam logic [7:0] CTL_FIVE_STEP = 8'h80;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 64;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    logic [1:0]          i_cfg_index   = '0;
    logic [PERIOD_W-1:0] i_cfg_wdata   = '0;

    // Pacing of both sides, set by the stimulus process.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_long_hold = 1'b0;

    // Owned by the receiver process.
    bit rx_hold_done = 1'b0;
    int rx_hold_left = LONG_HOLD_CYCLES;

    int idle_cycles = 0;
    int n_ticks     = 0;
    int n_writes    = 0;
    int n_reads     = 0;
    int n_unused    = 0;
    int n_settings  = 0;

    int failures;
    int outstanding;
    int checked;
    int env_pulses;
    int len_pulses;
    int irq_results;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    apu_frame_sequencer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    apu_frame_sequencer_core_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_failures    (failures),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_env_pulses  (env_pulses),
        .o_len_pulses  (len_pulses),
        .o_irq_results (irq_results)
    );

    // Receiver: random stalls, plus one long hold-off that lets the block fill up.
    always @(negedge i_clk) begin
        if (rx_long_hold && !rx_hold_done) begin
            m_axis_tready <= 1'b0;
            if (rx_hold_left == 1)
                rx_hold_done <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Watchdog: give up when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("No item moved for %0d cycles, %0d results still due.",
                     WATCHDOG_LIMIT, outstanding);
            $display("apu_frame_sequencer_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, with random idle cycles first, and wait until it is taken.
    task automatic send_item(input logic [1:0] kind, input logic [4:0] index,
                             input logic [7:0] wbyte, input logic dmc);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, dmc, wbyte, index};
        do @(posedge i_clk); while (!s_axis_tready);
        case (kind)
            OP_TICK:  n_ticks++;
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            default:  n_unused++;
        endcase
        @(negedge i_clk);
    endtask

    // Ticks ignore the other fields, so those carry random bits.
    task automatic send_ticks(input int count);
        repeat (count)
            send_item(OP_TICK, 5'($urandom_range(31, 0)), 8'($urandom_range(255, 0)),
                      1'($urandom_range(1, 0)));
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Period registers are rewritten only with the block idle.
    task automatic set_periods(input logic [PERIOD_W-1:0] frame_p,
                               input logic [PERIOD_W-1:0] quarter_p,
                               input logic [PERIOD_W-1:0] half_p);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_PERIOD;
        i_cfg_wdata <= frame_p;
        @(negedge i_clk);
        i_cfg_index <= CFG_QUARTER_PERIOD;
        i_cfg_wdata <= quarter_p;
        @(negedge i_clk);
        i_cfg_index <= CFG_HALF_PERIOD;
        i_cfg_wdata <= half_p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly ticks with occasional frame control writes and status reads; the
    // rest is accesses to random registers and the unused kind.
    task automatic random_phase(input int count);
        int         pick;
        logic [7:0] wbyte;
        logic       dmc;
        for (int k = 0; k < count; k++) begin
            pick  = $urandom_range(99, 0);
            wbyte = 8'($urandom_range(255, 0));
            dmc   = 1'($urandom_range(1, 0));
            if (pick < 72) begin
                send_ticks(1);
            end else if (pick < 74) begin
                // Favor four-step mode with the interrupt allowed.
                if ($urandom_range(2, 0) != 0)
                    wbyte[7:6] = 2'b00;
                send_item(OP_WRITE, REG_FRAME, wbyte, dmc);
            end else if (pick < 80) begin
                send_item(OP_READ, REG_STATUS, wbyte, dmc);
            end else if (pick < 87) begin
                send_item(OP_READ, 5'($urandom_range(31, 0)), wbyte, dmc);
            end else if (pick < 95) begin
                send_item(OP_WRITE, 5'($urandom_range(31, 0)), wbyte, dmc);
            end else begin
                send_item(OP_UNUSED, 5'($urandom_range(31, 0)), wbyte, dmc);
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A few items with the reset periods.
        send_ticks(4);
        send_item(OP_READ, REG_STATUS, 8'h00, 1'b1);

        // Directed items with the shortest periods.
        set_periods(15'd8, 15'd8, 15'd3731);
        // Four-step mode with the interrupt allowed, applied at the next even tick.
        send_item(OP_WRITE, REG_FRAME, CTL_FOUR_STEP, 1'b0);
        send_ticks(2);
        send_item(OP_READ, REG_STATUS, 8'h00, 1'b1);
        // A read that arrives before the pending write is applied replaces it.
        send_item(OP_WRITE, REG_FRAME, 8'hFF, 1'b1);
        send_item(OP_READ, REG_STATUS, 8'hFF, 1'b0);
        send_ticks(2);
        // Five-step mode raises both clock pulses on the tick after it is applied.
        send_item(OP_WRITE, REG_FRAME, CTL_FIVE_STEP, 1'b0);
        send_ticks(3);
        // Other registers are latched and then ignored; a read of one returns zero.
        send_item(OP_WRITE, REG_LAST_INDEX, 8'hFF, 1'b1);
        send_item(OP_READ, REG_FIRST_INDEX, 8'h00, 1'b1);
        send_ticks(2);
        send_item(OP_UNUSED, REG_LAST_INDEX, 8'hFF, 1'b1);
        // Interrupt inhibit, then a status write and a frame register read.
        send_item(OP_WRITE, REG_FRAME, 8'h40, 1'b0);
        send_ticks(2);
        send_item(OP_WRITE, REG_STATUS, 8'h55, 1'b0);
        send_item(OP_READ, REG_FRAME, 8'h00, 1'b0);
        send_ticks(2);
        send_item(OP_WRITE, REG_FRAME, CTL_FOUR_STEP, 1'b0);

        // Random items, no idling on either side.
        random_phase(200);

        // Sender mostly idle, with one pause until every result has come out.
        set_periods(15'($urandom_range(14, 8)), 15'($urandom_range(14, 8)),
                    15'($urandom_range(3740, 3731)));
        tx_idle_pct = 83;
        random_phase(110);
        drain_and_settle();
        random_phase(110);
        tx_idle_pct = 0;

        // Longest periods, receiver mostly stalled.
        set_periods(15'd32767, 15'd32767, 15'd32767);
        rx_stall_pct = 83;
        random_phase(200);
        rx_stall_pct = 0;

        // Short periods again, so counters left above them expire at once; both
        // sides idle now and then and the receiver holds off once for a long time.
        set_periods(15'd9, 15'd10, 15'd3731);
        tx_idle_pct  = 8;
        rx_stall_pct = 8;
        rx_long_hold = 1'b1;
        random_phase(200);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        drain_and_settle();
        $display("Sent %0d items (%0d ticks, %0d writes, %0d reads, %0d of the unused kind)",
                 n_ticks + n_writes + n_reads + n_unused, n_ticks, n_writes, n_reads,
                 n_unused);
        $display("under %0d period settings; compared %0d results: %0d envelope pulses,",
                 n_settings, checked, env_pulses);
        $display("%0d length pulses, %0d with the frame interrupt set.",
                 len_pulses, irq_results);
        if (failures == 0 && outstanding == 0) begin
            $display("apu_frame_sequencer_core verification clean");
        end else begin
            $display("apu_frame_sequencer_core verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/afs_pkg.sv
hw/rtl/afs_cfg_regs.sv
hw/rtl/afs_seq_logic.sv
hw/rtl/apu_frame_sequencer_core.sv
verif/apu_frame_sequencer_core_checker.sv
verif/apu_frame_sequencer_core_tb.sv
